// File: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, widths and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int ARENA_BYTES_DEF  = 65536;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int OFF_W   = 16;
    localparam int SIZE_W  = 17;
    localparam int STAT_W  = 3;
    localparam int SUM_W   = 26;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_OOM   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NEVER = 3'd2;
    localparam logic [STAT_W-1:0] ST_FREED = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic REG_ARENA_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DECIDE,
        S_UPDATE,
        S_HOLD
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MARK,
        OP_SPLIT,
        OP_APPEND,
        OP_FREE,
        OP_MERGE_PREV,
        OP_MERGE_NEXT,
        OP_MERGE_BOTH
    } op_t;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] sz;
        logic              fr;
    } cell_data_t;

    typedef struct packed {
        logic fit;
        logic split_ok;
        logic hit;
        logic pf;
        logic nf;
        logic fr;
    } cell_flags_t;

    typedef struct packed {
        op_t               op;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  top;
    } cell_ctrl_t;

endpackage

// File: rtl/ffa_req_if.sv
// ----------------------------------------------------------------------------
// ffa_req_if
// Request channel: allocate or release, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [ffa_pkg::SIZE_W-1:0]   request_size;
    logic [ffa_pkg::OFF_W-1:0]    release_address;

    modport source (output valid, action, request_size, release_address, input ready);
    modport sink   (input valid, action, request_size, release_address, output ready);
endinterface

// File: rtl/ffa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Response channel: granted address, status and zero-size warning.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ffa_pkg::OFF_W-1:0]    payload_address;
    logic [ffa_pkg::STAT_W-1:0]   status;
    logic                         zero_size_warning;

    modport source (output valid, payload_address, status, zero_size_warning, input ready);
    modport sink   (input valid, payload_address, status, zero_size_warning, output ready);
endinterface

// File: rtl/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One table entry: holds a block, flags it against the request, and shifts.
// ----------------------------------------------------------------------------
module ffa_cell #(
    parameter int IDX          = 0,
    parameter int CNT_W        = 7,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        eval,
    input  logic                        upd,
    input  logic [CNT_W-1:0]            count,
    input  logic [ffa_pkg::SIZE_W-1:0]  size,
    input  logic [ffa_pkg::OFF_W-1:0]   addr,
    input  ffa_pkg::cell_data_t         prev_d,
    input  ffa_pkg::cell_data_t         next_d,
    input  ffa_pkg::cell_data_t         next2_d,
    input  logic                        sel_self,
    input  logic                        sel_prev,
    input  logic                        sel_next,
    input  logic                        gt_self,
    input  ffa_pkg::cell_ctrl_t         ctrl,
    output ffa_pkg::cell_data_t         data,
    output ffa_pkg::cell_flags_t        flags
);
    localparam int W = ffa_pkg::SIZE_W + 2;
    localparam logic [W-1:0] HDR = W'(HEADER_BYTES);
    localparam logic [W-1:0] ADDR_MAX = W'(17'h0FFFF);

    ffa_pkg::cell_data_t  data_reg, data_next;
    ffa_pkg::cell_flags_t flags_reg, flags_next;
    logic                 valid;
    logic                 nvalid;
    logic [W-1:0]         pay;

    assign valid  = CNT_W'(IDX) < count;
    assign nvalid = (CNT_W+1)'(IDX + 1) < {1'b0, count};
    assign pay    = W'(data_reg.off) + HDR;

    always_comb
    begin
        flags_next.fr       = data_reg.fr;
        flags_next.fit      = valid && data_reg.fr && (W'(data_reg.sz) >= W'(size))
                              && (pay <= ADDR_MAX);
        flags_next.split_ok = W'(data_reg.sz) >= (W'(size) + HDR);
        flags_next.hit      = valid && (pay == W'(addr));
        flags_next.pf       = (IDX > 0) && prev_d.fr;
        flags_next.nf       = nvalid && next_d.fr;
    end

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            ffa_pkg::OP_MARK:
            begin
                if (sel_self)
                    data_next.fr = 1'b0;
            end
            ffa_pkg::OP_SPLIT:
            begin
                if (sel_self)
                begin
                    data_next.sz = ctrl.size;
                    data_next.fr = 1'b0;
                end
                else if (sel_prev)
                begin
                    data_next.off = ffa_pkg::OFF_W'(W'(prev_d.off) + HDR + W'(ctrl.size));
                    data_next.sz  = ffa_pkg::SIZE_W'(W'(prev_d.sz) - HDR - W'(ctrl.size));
                    data_next.fr  = 1'b1;
                end
                else if (gt_self)
                    data_next = prev_d;
            end
            ffa_pkg::OP_APPEND:
            begin
                if (sel_self)
                begin
                    data_next.off = ctrl.top;
                    data_next.sz  = ctrl.size;
                    data_next.fr  = 1'b0;
                end
            end
            ffa_pkg::OP_FREE:
            begin
                if (sel_self)
                    data_next.fr = 1'b1;
            end
            ffa_pkg::OP_MERGE_PREV:
            begin
                if (sel_next)
                    data_next.sz = ffa_pkg::SIZE_W'(W'(data_reg.sz) + HDR + W'(next_d.sz));
                else if (sel_self || gt_self)
                    data_next = next_d;
            end
            ffa_pkg::OP_MERGE_NEXT:
            begin
                if (sel_self)
                begin
                    data_next.sz = ffa_pkg::SIZE_W'(W'(data_reg.sz) + HDR + W'(next_d.sz));
                    data_next.fr = 1'b1;
                end
                else if (gt_self)
                    data_next = next_d;
            end
            ffa_pkg::OP_MERGE_BOTH:
            begin
                if (sel_next)
                    data_next.sz = ffa_pkg::SIZE_W'(W'(data_reg.sz) + HDR + HDR
                                   + W'(next_d.sz) + W'(next2_d.sz));
                else if (sel_self || gt_self)
                    data_next = next2_d;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (eval)
            flags_reg <= flags_next;
        if (upd)
            data_reg <= data_next;
    end

    assign data  = data_reg;
    assign flags = flags_reg;

endmodule

// File: rtl/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit block allocator with split on allocate and merge on release.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------------
//  req     | in  | valid/ready             | action, request_size,
//          |     |                         | release_address
//  rsp     | out | valid/ready             | payload_address, status,
//          |     |                         | zero_size_warning
//  apb     | in  | psel/penable, pready=1  | paddr, pwdata, prdata
//
//  An item passes through accept, cell evaluate, decide and table update, in
//  that order. The steps are set by the row of cells: flags are registered in
//  every cell, the first match is picked from the flag vector, then every cell shifts at once.
//  Reset clears the block count and heap top and sets the arena limit to
//  65536; cell contents need no reset since only cells below the count are read.
//  A stalled response holds in the output register; the sequencer waits in
//  its hold state and accepts no new request until the result is taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
    parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ffa_req_if.sink                       req,
    ffa_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffa_pkg::PADDR_W-1:0]   paddr,
    input  logic [ffa_pkg::PDATA_W-1:0]   pwdata,
    output logic [ffa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    localparam int N      = MAX_BLOCKS;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W  = ffa_pkg::SUM_W;
    localparam int SIZE_W = ffa_pkg::SIZE_W;
    localparam int OFF_W  = ffa_pkg::OFF_W;
    localparam logic [SUM_W-1:0] HDR      = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] ARENA_L  = SUM_W'(ARENA_BYTES);
    localparam logic [SUM_W-1:0] ADDR_MAX = SUM_W'(17'h0FFFF);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BLOCKS);
    localparam logic [N-1:0]     ONE_N    = N'(1);

    // Control state
    ffa_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [SIZE_W-1:0]          top_reg, top_next;
    logic [SIZE_W-1:0]          limit_reg;

    // Captured request
    logic                       act_reg;
    logic [SIZE_W-1:0]          size_reg;
    logic [OFF_W-1:0]           addr_reg;

    // Decision registered for the update cycle
    ffa_pkg::op_t               op_reg, op_next;
    logic [N-1:0]               sel_reg, sel_next;
    logic [N-1:0]               gt_reg;
    logic [SIZE_W-1:0]          topn_reg, topn_next;
    logic [OFF_W-1:0]           raddr_reg, raddr_next;
    logic [ffa_pkg::STAT_W-1:0] rstat_reg, rstat_next;
    logic                       rwarn_reg;

    // Response register
    logic                       ovalid_reg, ovalid_next;
    logic [OFF_W-1:0]           oaddr_reg;
    logic [ffa_pkg::STAT_W-1:0] ostat_reg;
    logic                       owarn_reg;
    logic                       load;

    // Cell row
    ffa_pkg::cell_data_t        cdata  [N];
    ffa_pkg::cell_flags_t       cflags [N];
    ffa_pkg::cell_ctrl_t        ctrl;
    logic [N-1:0]               fit_v, split_v, hit_v, pf_v, nf_v, fr_v;
    logic [N-1:0]               first_fit, first_hit;

    ffa_pkg::cell_data_t        zero_d;
    assign zero_d = '0;

    assign ctrl.op   = op_reg;
    assign ctrl.size = size_reg;
    assign ctrl.top  = top_reg[OFF_W-1:0];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            ffa_cell #(
                .IDX          (g),
                .CNT_W        (CNT_W),
                .HEADER_BYTES (HEADER_BYTES)
            ) u_cell (
                .clk      (clk),
                .eval     (state_reg == ffa_pkg::S_EVAL),
                .upd      (state_reg == ffa_pkg::S_UPDATE),
                .count    (count_reg),
                .size     (size_reg),
                .addr     (addr_reg),
                .prev_d   ((g > 0)     ? cdata[(g > 0) ? g - 1 : 0]     : zero_d),
                .next_d   ((g + 1 < N) ? cdata[(g + 1 < N) ? g + 1 : g] : zero_d),
                .next2_d  ((g + 2 < N) ? cdata[(g + 2 < N) ? g + 2 : g] : zero_d),
                .sel_self (sel_reg[g]),
                .sel_prev ((g > 0)     ? sel_reg[(g > 0) ? g - 1 : 0]     : 1'b0),
                .sel_next ((g + 1 < N) ? sel_reg[(g + 1 < N) ? g + 1 : g] : 1'b0),
                .gt_self  (gt_reg[g]),
                .ctrl     (ctrl),
                .data     (cdata[g]),
                .flags    (cflags[g])
            );
            assign fit_v[g]   = cflags[g].fit;
            assign split_v[g] = cflags[g].split_ok;
            assign hit_v[g]   = cflags[g].hit;
            assign pf_v[g]    = cflags[g].pf;
            assign nf_v[g]    = cflags[g].nf;
            assign fr_v[g]    = cflags[g].fr;
        end
    endgenerate

    // Lowest set bit isolates the first match in table order
    assign first_fit = fit_v & (~fit_v + ONE_N);
    assign first_hit = hit_v & (~hit_v + ONE_N);

    logic [SUM_W-1:0] pay_first;
    logic [SUM_W-1:0] lim_eff;
    logic [SUM_W-1:0] top_sum;

    always_comb
    begin
        pay_first = '0;
        for (int k = 0; k < N; k++)
        begin
            if (first_fit[k])
                pay_first = pay_first | (SUM_W'(cdata[k].off) + HDR);
        end
    end

    assign lim_eff = (SUM_W'(limit_reg) > ARENA_L) ? ARENA_L : SUM_W'(limit_reg);
    assign top_sum = SUM_W'(top_reg) + HDR + SUM_W'(size_reg);

    // Decide the table operation and the result from the registered flags
    always_comb
    begin
        op_next    = ffa_pkg::OP_NONE;
        sel_next   = '0;
        topn_next  = top_reg;
        raddr_next = '0;
        rstat_next = ffa_pkg::ST_OK;
        if (act_reg == ffa_pkg::ACT_ALLOC)
        begin
            if (|fit_v)
            begin
                sel_next   = first_fit;
                raddr_next = pay_first[OFF_W-1:0];
                if ((|(first_fit & split_v)) && (count_reg < CNT_MAX))
                    op_next = ffa_pkg::OP_SPLIT;
                else
                    op_next = ffa_pkg::OP_MARK;
            end
            else if (count_reg >= CNT_MAX)
                rstat_next = ffa_pkg::ST_FULL;
            else if ((top_sum > lim_eff) || ((SUM_W'(top_reg) + HDR) > ADDR_MAX))
                rstat_next = ffa_pkg::ST_OOM;
            else
            begin
                op_next    = ffa_pkg::OP_APPEND;
                sel_next   = ONE_N << count_reg;
                raddr_next = OFF_W'(SUM_W'(top_reg) + HDR);
                topn_next  = SIZE_W'(top_sum);
            end
        end
        else
        begin
            sel_next = first_hit;
            if (!(|hit_v))
                rstat_next = ffa_pkg::ST_NEVER;
            else if (|(first_hit & fr_v))
                rstat_next = ffa_pkg::ST_FREED;
            else
            begin
                case ({|(first_hit & pf_v), |(first_hit & nf_v)})
                    2'b11:   op_next = ffa_pkg::OP_MERGE_BOTH;
                    2'b10:   op_next = ffa_pkg::OP_MERGE_PREV;
                    2'b01:   op_next = ffa_pkg::OP_MERGE_NEXT;
                    default: op_next = ffa_pkg::OP_FREE;
                endcase
            end
        end
        if (rstat_next != ffa_pkg::ST_OK)
            sel_next = '0;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (req.valid)
                    state_next = ffa_pkg::S_EVAL;
            end
            ffa_pkg::S_EVAL:
            begin
                state_next = ffa_pkg::S_DECIDE;
            end
            ffa_pkg::S_DECIDE:
            begin
                state_next = ffa_pkg::S_UPDATE;
            end
            ffa_pkg::S_UPDATE,
            ffa_pkg::S_HOLD:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    load       = 1'b1;
                    state_next = ffa_pkg::S_IDLE;
                end
                else
                    state_next = ffa_pkg::S_HOLD;
            end
            default:
            begin
                state_next = ffa_pkg::S_IDLE;
            end
        endcase
    end

    // Block count and heap top change in the update cycle only
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (state_reg == ffa_pkg::S_UPDATE)
        begin
            case (op_reg)
                ffa_pkg::OP_SPLIT:      count_next = count_reg + CNT_W'(1);
                ffa_pkg::OP_APPEND:
                begin
                    count_next = count_reg + CNT_W'(1);
                    top_next   = topn_reg;
                end
                ffa_pkg::OP_MERGE_PREV,
                ffa_pkg::OP_MERGE_NEXT: count_next = count_reg - CNT_W'(1);
                ffa_pkg::OP_MERGE_BOTH: count_next = count_reg - CNT_W'(2);
                default:                count_next = count_reg;
            endcase
        end
    end

    assign ovalid_next = load || (ovalid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ffa_pkg::S_IDLE;
            count_reg  <= '0;
            top_reg    <= '0;
            limit_reg  <= SIZE_W'(65536);
            ovalid_reg <= 1'b0;
            op_reg     <= ffa_pkg::OP_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            ovalid_reg <= ovalid_next;
            if (psel && penable && pwrite && paddr[2] == ffa_pkg::REG_ARENA_LIMIT)
                limit_reg <= pwdata[SIZE_W-1:0];
            if (state_reg == ffa_pkg::S_DECIDE)
                op_reg <= op_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            act_reg  <= req.action;
            size_reg <= req.request_size;
            addr_reg <= req.release_address;
        end
        if (state_reg == ffa_pkg::S_DECIDE)
        begin
            sel_reg   <= sel_next;
            gt_reg    <= ~(sel_next | (sel_next - ONE_N));
            topn_reg  <= topn_next;
            raddr_reg <= raddr_next;
            rstat_reg <= rstat_next;
            rwarn_reg <= (act_reg == ffa_pkg::ACT_ALLOC) && (size_reg == '0);
        end
        if (load)
        begin
            oaddr_reg <= raddr_reg;
            ostat_reg <= rstat_reg;
            owarn_reg <= rwarn_reg;
        end
    end

    assign req.ready             = (state_reg == ffa_pkg::S_IDLE);
    assign rsp.valid             = ovalid_reg;
    assign rsp.payload_address   = oaddr_reg;
    assign rsp.status            = ostat_reg;
    assign rsp.zero_size_warning = owarn_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ffa_pkg::REG_ARENA_LIMIT) ?
                    ffa_pkg::PDATA_W'(limit_reg) : '0;

    // The table never holds more blocks than cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("block count above cell count");

    // Exactly one cell or none is targeted by an update
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffa_pkg::S_UPDATE |-> $onehot0(sel_reg))
        else $error("more than one target cell");

    // A failed request never grants an address
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ffa_pkg::ST_OK |-> rsp.payload_address == '0)
        else $error("address granted on failure");

    // The heap top moves only in the update cycle
    a_top_mono: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ffa_pkg::S_UPDATE |=> top_reg == $past(top_reg))
        else $error("heap top moved outside update");

endmodule
